### rtl/core/slcfr_pkg.sv
// ----------------------------------------------------------------------------
// slcfr_pkg
// Shared types, codes and the CRC-8 step for the sync/length frame receiver.
// ----------------------------------------------------------------------------
package slcfr_pkg;

  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam logic [7:0] CRC_TOP  = 8'h80;

  localparam int unsigned PREFIX_BYTES = 4;
  localparam int unsigned MIN_BODY     = 7;
  localparam int unsigned POS_VERSION  = 4;
  localparam int unsigned POS_SEQ_LO   = 5;
  localparam int unsigned POS_SEQ_HI   = 6;
  localparam int unsigned POS_TYPE_LO  = 7;
  localparam int unsigned POS_TYPE_HI  = 8;
  localparam int unsigned POS_PAYLOAD  = 10;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // config register indexes
  localparam logic REG_SYNC    = 1'b0;
  localparam logic REG_VERSION = 1'b1;

  typedef enum logic [1:0] {
    ST_GOOD    = 2'd0,
    ST_CRC     = 2'd1,
    ST_VERSION = 2'd2
  } status_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic [15:0] seq;
    logic [15:0] mtype;
    logic [7:0]  plen;
    status_t     status;
  } event_t;

  // One byte through CRC-8, MSB first, no reflection.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 8'h00) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

### rtl/core/slcfr_front.sv
// ----------------------------------------------------------------------------
// slcfr_front
// Sync hunt over a 3-byte window plus the arriving byte, then header and
// payload tracking with running CRC. Emits one event per request at most.
// ----------------------------------------------------------------------------
module slcfr_front #(
  parameter int unsigned MAX_FRAME_BYTES = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_fire,
  input  logic [7:0]          in_byte,
  input  logic [15:0]         sync_word,
  input  logic [7:0]          protocol_version,
  output logic                ev_valid,
  output slcfr_pkg::event_t   ev
);
  import slcfr_pkg::*;

  localparam int unsigned LEN_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [15:0] MAX_BODY = 16'(MAX_FRAME_BYTES - PREFIX_BYTES);

  logic [23:0]      window, window_next;
  logic [1:0]       fill, fill_next;
  logic             in_frame, in_frame_next;
  logic [LEN_W-1:0] frame_total, frame_total_next;
  logic [LEN_W-1:0] pos, pos_next;
  logic [7:0]       crc, crc_next;
  logic [7:0]       version, version_next;
  logic [15:0]      seq, seq_next;
  logic [15:0]      mtype, mtype_next;
  logic [7:0]       plen, plen_next;

  logic [31:0] w;
  logic [15:0] body;
  logic [15:0] body_m7;
  logic        is_last;

  assign w       = {in_byte, window};
  assign body    = w[31:16];
  assign body_m7 = body - 16'(MIN_BODY);
  assign is_last = ({1'b0, pos} + (LEN_W+1)'(1)) >= {1'b0, frame_total};

  always_comb begin
    window_next      = window;
    fill_next        = fill;
    in_frame_next    = in_frame;
    frame_total_next = frame_total;
    pos_next         = pos;
    crc_next         = crc;
    version_next     = version;
    seq_next         = seq;
    mtype_next       = mtype;
    plen_next        = plen;
    ev_valid         = 1'b0;
    ev               = '0;
    ev.seq           = seq;
    ev.mtype         = mtype;
    ev.plen          = plen;
    ev.status        = ST_GOOD;

    if (in_fire) begin
      if (in_frame) begin
        if (is_last) begin
          ev_valid      = 1'b1;
          ev.kind       = KIND_SUMMARY;
          if (in_byte != crc) begin
            ev.status = ST_CRC;
          end else if (version != protocol_version) begin
            ev.status = ST_VERSION;
          end
          in_frame_next = 1'b0;
          fill_next     = 2'd0;
        end else begin
          crc_next = crc8_byte(crc, in_byte);
          pos_next = pos + LEN_W'(1);
          case (pos)
            LEN_W'(POS_VERSION): version_next     = in_byte;
            LEN_W'(POS_SEQ_LO):  seq_next[7:0]    = in_byte;
            LEN_W'(POS_SEQ_HI):  seq_next[15:8]   = in_byte;
            LEN_W'(POS_TYPE_LO): mtype_next[7:0]  = in_byte;
            LEN_W'(POS_TYPE_HI): mtype_next[15:8] = in_byte;
            default: begin
              if (pos >= LEN_W'(POS_PAYLOAD)) begin
                ev_valid = 1'b1;
                ev.kind  = KIND_PAYLOAD;
                ev.data  = in_byte;
              end
            end
          endcase
        end
      end else begin
        case (fill)
          2'd0: begin
            window_next[7:0] = in_byte;
            fill_next        = 2'd1;
          end
          2'd1: begin
            window_next[15:8] = in_byte;
            fill_next         = 2'd2;
          end
          2'd2: begin
            window_next[23:16] = in_byte;
            fill_next          = 2'd3;
          end
          default: begin
            if (w[15:0] != sync_word || body < 16'(MIN_BODY)) begin
              // slide by one byte and keep hunting
              window_next = w[31:8];
              fill_next   = 2'd3;
            end else if (body > MAX_BODY) begin
              fill_next = 2'd0;
            end else begin
              crc_next         = crc8_byte(crc8_byte(crc8_byte(crc8_byte(8'h00, w[7:0]),
                                   w[15:8]), w[23:16]), w[31:24]);
              frame_total_next = LEN_W'(body) + LEN_W'(PREFIX_BYTES);
              pos_next         = LEN_W'(PREFIX_BYTES);
              plen_next        = (body_m7 > 16'd255) ? 8'd255 : body_m7[7:0];
              in_frame_next    = 1'b1;
              fill_next        = 2'd0;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= 2'd0;
      in_frame <= 1'b0;
    end else begin
      fill     <= fill_next;
      in_frame <= in_frame_next;
    end
    window      <= window_next;
    frame_total <= frame_total_next;
    pos         <= pos_next;
    crc         <= crc_next;
    version     <= version_next;
    seq         <= seq_next;
    mtype       <= mtype_next;
    plen        <= plen_next;
  end

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    in_frame |-> pos < frame_total)
    else $error("frame position past frame length");

  a_min_frame: assert property (@(posedge clk) disable iff (rst)
    in_frame |-> frame_total >= LEN_W'(PREFIX_BYTES + MIN_BODY))
    else $error("frame shorter than header");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_frame && is_last) |=> (!in_frame && fill == 2'd0))
    else $error("frame did not close after final byte");

endmodule

### rtl/core/slcfr_queue.sv
// ----------------------------------------------------------------------------
// slcfr_queue
// Two-entry event queue between the deframer and the output channel.
// ----------------------------------------------------------------------------
module slcfr_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  slcfr_pkg::event_t push_ev,
  output logic              full,
  output logic              out_valid,
  input  logic              out_ready,
  output slcfr_pkg::event_t head
);
  import slcfr_pkg::*;

  event_t     slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && out_ready;
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
    if (push) begin
      slots[wr_ptr] <= push_ev;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2)
    else $error("queue count out of range");

  a_ptr_track: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'd2) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with count");

endmodule

### rtl/core/sync_length_crc8_frame_receiver.sv
// ----------------------------------------------------------------------------
// sync_length_crc8_frame_receiver
// Deframes length-prefixed frames with sync word and CRC-8 check; emits
// each payload byte and a summary with status per frame.
//
//   channel  signals                                   dir  payload
//   rx       rx_valid / rx_ready                       in   rx_byte
//   out      out_valid / out_ready                     out  event_kind .. frame_status
//   cfg      cfg_valid / cfg_ready                     in   cfg_index, cfg_data
//
// One received byte per cycle; at most one event per byte. The event is
// written into the queue by the clock edge that accepts its byte, and the
// output is driven from that registered queue entry.
// A two-entry queue separates the deframer from the output; rx_ready drops
// only when that queue is full. cfg_ready is always high.
// Synchronous reset clears the hunt, frame state and both registers.
// ----------------------------------------------------------------------------
module sync_length_crc8_frame_receiver #(
  parameter int unsigned MAX_FRAME_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        event_kind,
  output logic [7:0]  payload_byte,
  output logic [15:0] seq_number,
  output logic [15:0] msg_type,
  output logic [7:0]  payload_size,
  output logic [1:0]  frame_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import slcfr_pkg::*;

  logic [15:0] sync_word;
  logic [7:0]  protocol_version;
  logic        in_fire;
  logic        ev_valid;
  event_t      ev;
  logic        q_full;
  event_t      head;

  assign cfg_ready = 1'b1;
  assign rx_ready  = !q_full;
  assign in_fire   = rx_valid && rx_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_word        <= 16'h0000;
      protocol_version <= 8'h00;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SYNC:    sync_word        <= cfg_data;
        REG_VERSION: protocol_version <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  slcfr_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .in_fire         (in_fire),
    .in_byte         (rx_byte),
    .sync_word       (sync_word),
    .protocol_version(protocol_version),
    .ev_valid        (ev_valid),
    .ev              (ev)
  );

  slcfr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (ev_valid),
    .push_ev  (ev),
    .full     (q_full),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .head     (head)
  );

  assign event_kind   = head.kind;
  assign payload_byte = head.data;
  assign seq_number   = head.seq;
  assign msg_type     = head.mtype;
  assign payload_size = head.plen;
  assign frame_status = head.status;

endmodule
